/* sv/vtpd_pkg.sv */
`timescale 1ns / 1ps

package vtpd_pkg;

  localparam int POS_W          = 5;
  localparam int PKT_LEN        = 27;
  localparam int POS_HDR0       = 0;
  localparam int POS_HDR1       = 1;
  localparam int POS_BODY       = 2;
  localparam int POS_CSUM       = PKT_LEN - 1;
  localparam int BODY_BYTES     = POS_CSUM - POS_BODY;
  localparam int REC_LEN        = 11;
  localparam int TGT0_OFS       = 4 - POS_BODY;
  localparam int TGT1_OFS       = 15 - POS_BODY;
  localparam int SEQ_OFS        = 2 - POS_BODY;
  localparam int FLAGS_OFS      = 3 - POS_BODY;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h55;

  localparam logic [7:0] FLAG_T0_VALID = 8'h01;
  localparam logic [7:0] FLAG_T0_STALE = 8'h02;
  localparam logic [7:0] FLAG_T1_VALID = 8'h04;
  localparam logic [7:0] FLAG_T1_STALE = 8'h08;

  localparam logic       FUNC_BYTE = 1'b0;
  localparam logic       FUNC_TICK = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
  localparam int          TIMER_BITS_DEF = 16;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic               online;
    logic        [7:0]  sequence_res;
    logic               target_id;
    logic               target_valid;
    logic               target_stale;
    logic        [7:0]  quality;
    logic        [15:0] center_x;
    logic        [15:0] center_y;
    logic signed [15:0] error_x;
    logic signed [15:0] error_y;
    logic        [15:0] blob_area;
    logic               last;
  } result_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic pkt;
    logic off;
    logic bank;
  } emit_req_t;

endpackage

/* sv/vtpd_emit.sv */
`timescale 1ns / 1ps

module vtpd_emit (
  input  logic                clk,
  input  logic                rst,
  input  vtpd_pkg::store_wr_t wr,
  input  vtpd_pkg::emit_req_t req,
  output logic                busy,
  output logic                result_valid,
  input  logic                result_ready,
  output vtpd_pkg::result_t   result
);
  import vtpd_pkg::*;

  localparam int ADDR_W = POS_W + 1;
  localparam int CNT_W  = POS_W;

  typedef enum logic [1:0] {IDLE, FETCH, SEND0, SEND1} state_t;

  logic [7:0]            mem [2**ADDR_W];
  logic [7:0]            rd_data;
  logic                  rd_en;
  logic [POS_W-1:0]      rd_pos;

  state_t                state;
  logic                  off;
  logic                  rd_bank;
  logic                  rd_pend;
  logic [CNT_W-1:0]      rd_cnt;
  logic [BODY_BYTES*8-1:0] pkt_bytes;

  logic                  tgt;
  logic [7:0]            flags;
  logic [REC_LEN*8-1:0]  rec;
  logic                  t_valid;
  logic                  t_stale;

  assign rd_en  = (state == FETCH) && (rd_cnt < CNT_W'(BODY_BYTES));
  assign rd_pos = POS_W'(POS_BODY) + rd_cnt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.pos}] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[{rd_bank, rd_pos}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      off     <= 1'b0;
      rd_bank <= 1'b0;
      rd_pend <= 1'b0;
      rd_cnt  <= '0;
    end else begin
      rd_pend <= rd_en;
      if (rd_pend) begin
        pkt_bytes <= {rd_data, pkt_bytes[BODY_BYTES*8-1:8]};
      end
      case (state)
        IDLE: begin
          if (req.pkt) begin
            state   <= FETCH;
            off     <= 1'b0;
            rd_bank <= req.bank;
            rd_cnt  <= '0;
          end else if (req.off) begin
            state <= SEND0;
            off   <= 1'b1;
          end
        end
        FETCH: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (rd_pend && !rd_en) begin
            state <= SEND0;
          end
        end
        SEND0: begin
          if (result_ready) begin
            state <= SEND1;
          end
        end
        SEND1: begin
          if (result_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign busy         = (state != IDLE);
  assign result_valid = (state == SEND0) || (state == SEND1);

  assign tgt   = (state == SEND1);
  assign flags = pkt_bytes[FLAGS_OFS*8 +: 8];
  assign rec   = tgt ? pkt_bytes[TGT1_OFS*8 +: REC_LEN*8]
                     : pkt_bytes[TGT0_OFS*8 +: REC_LEN*8];
  assign t_valid = tgt ? |(flags & FLAG_T1_VALID) : |(flags & FLAG_T0_VALID);
  assign t_stale = tgt ? |(flags & FLAG_T1_STALE) : |(flags & FLAG_T0_STALE);

  always_comb begin
    result           = '0;
    result.target_id = tgt;
    result.last      = tgt;
    if (!off) begin
      result.online       = 1'b1;
      result.sequence_res = pkt_bytes[SEQ_OFS*8 +: 8];
      result.target_valid = t_valid;
      result.target_stale = t_stale;
      if (t_valid) begin
        result.quality   = rec[7:0];
        result.center_x  = rec[23:8];
        result.center_y  = rec[39:24];
        result.error_x   = rec[55:40];
        result.error_y   = rec[71:56];
        result.blob_area = rec[87:72];
      end
    end
  end

endmodule

/* sv/vision_target_packet_deframer_unit.sv */
`timescale 1ns / 1ps
// channel  valid         ready         payload
// item     item_valid    item_ready    item   (func, rx_byte)
// result   result_valid  result_ready  result (two beats per event)
// config   cfg_valid     cfg_ready     cfg_data (offline timeout, ms)
//
// One item per cycle; a byte or tick with no result is never stalled.
// A good packet end or an offline tick waits while the previous pair is still out.
// A good packet fetches its 24 body bytes from the packet RAM, one per cycle,
// then sends two beats, target 0 first and then target 1,
// each beat held until result_ready is high.
// Synchronous reset clears framing, online and elapsed, and sets timeout to 500 ms.

module vision_target_packet_deframer_unit #(
  parameter int TIMER_BITS = vtpd_pkg::TIMER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  vtpd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output vtpd_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import vtpd_pkg::*;

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [POS_W-1:0]      pos, pos_next;
  logic [7:0]            csum, csum_next;
  logic                  wr_bank;
  logic                  is_online;
  logic [TIMER_BITS-1:0] elapsed, elapsed_inc;
  logic [15:0]           timeout;

  logic                  accept;
  logic                  good_pkt;
  logic                  go_off;
  logic                  busy;
  store_wr_t             wr;
  emit_req_t             req;

  assign cfg_ready   = 1'b1;
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + TIMER_BITS'(1);

  assign good_pkt = (item.func == FUNC_BYTE) && (pos == POS_W'(POS_CSUM))
                    && (csum == item.rx_byte);
  assign go_off   = (item.func == FUNC_TICK) && is_online
                    && (CMP_W'(elapsed_inc) > CMP_W'(timeout));

  assign item_ready = !(busy && (good_pkt || go_off));
  assign accept     = item_valid && item_ready;

  always_comb begin
    pos_next = pos;
    csum_next = csum;
    wr.en   = 1'b0;
    wr.bank = wr_bank;
    wr.pos  = pos;
    wr.data = item.rx_byte;
    case (pos) inside
      POS_W'(POS_HDR0): begin
        if (item.rx_byte == SYNC_A) begin
          wr.en    = 1'b1;
          pos_next = POS_W'(POS_HDR1);
        end
      end
      POS_W'(POS_HDR1): begin
        if (item.rx_byte == SYNC_B) begin
          wr.en     = 1'b1;
          pos_next  = POS_W'(POS_BODY);
          csum_next = '0;
        end else if (item.rx_byte == SYNC_A) begin
          wr.en  = 1'b1;
          wr.pos = POS_W'(POS_HDR0);
        end else begin
          pos_next = POS_W'(POS_HDR0);
        end
      end
      [POS_W'(POS_BODY):POS_W'(POS_CSUM - 1)]: begin
        wr.en     = 1'b1;
        csum_next = csum ^ item.rx_byte;
        pos_next  = pos + POS_W'(1);
      end
      POS_W'(POS_CSUM): begin
        wr.en    = 1'b1;
        pos_next = POS_W'(POS_HDR0);
      end
      default: begin
        pos_next = POS_W'(POS_HDR0);
      end
    endcase
    if (!(accept && (item.func == FUNC_BYTE))) begin
      wr.en     = 1'b0;
      pos_next  = pos;
      csum_next = csum;
    end
  end

  assign req.pkt  = accept && good_pkt;
  assign req.off  = accept && go_off;
  assign req.bank = wr_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      csum      <= '0;
      wr_bank   <= 1'b0;
      is_online <= 1'b0;
      elapsed   <= '0;
      timeout   <= TIMEOUT_RESET;
    end else begin
      pos  <= pos_next;
      csum <= csum_next;
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (accept && (item.func == FUNC_TICK)) begin
        elapsed <= elapsed_inc;
        if (go_off) begin
          is_online <= 1'b0;
        end
      end
      if (req.pkt) begin
        wr_bank   <= ~wr_bank;
        is_online <= 1'b1;
        elapsed   <= '0;
      end
    end
  end

  vtpd_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .req          (req),
    .busy         (busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_online_after_pkt: assert property (@(posedge clk) disable iff (rst)
    req.pkt |=> is_online)
    else $error("online not set after good packet");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.online == is_online))
    else $error("result online flag disagrees with link state");

  a_bank_hold: assert property (@(posedge clk) disable iff (rst)
    !req.pkt |=> $stable(wr_bank))
    else $error("packet bank changed without a good packet");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.pkt || req.off) |-> !busy)
    else $error("result pair started while previous pair in flight");

endmodule
